// File: design/tid_pkg.sv
// Package for the tabulated interpolation and derivative block.
// Holds constants, command and status codes, shared types and the saturation function.
// No dependencies.
`default_nettype none

package tid_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_IDX_W = 12;
  localparam int SQ_STEPS    = 32;
  localparam int VW_EFF      = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VW_EFF - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DERIV  = 2'd1,
    CMD_INTERP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NEG   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_STEP_INV  = 2'd0,
    CFG_TWO_H     = 2'd1,
    CFG_INV_TWO_H = 2'd2
  } cfg_idx_e;

  // Control that travels with every word down the pipeline.
  typedef struct packed {
    logic valid;
    cmd_e cmd;
    logic neg;
    logic oob_a;
    logic oob_b;
  } ctl_t;

  // Table write carried to the lookup stage.
  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] idx;
    logic [31:0]            data;
  } wr_t;

  typedef logic [2:0][31:0] trip_t;

  function automatic logic [31:0] sat_value(input logic signed [63:0] x);
    if (x > SAT_HI) return SAT_HI[31:0];
    if (x < SAT_LO) return SAT_LO[31:0];
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

// File: design/tid_ram.sv
// Generic memory with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module tid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: design/tid_sqrt.sv
// Pipelined floor square root for two arguments, one result bit per stage.
// Depends on tid_pkg.
`default_nettype none

module tid_sqrt (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire tid_pkg::ctl_t ctl_i,
  input  wire tid_pkg::wr_t  wr_i,
  input  wire logic [30:0]   radius_i,
  input  wire logic [63:0]   xa_i,
  input  wire logic [63:0]   xb_i,
  output tid_pkg::ctl_t      ctl_o,
  output tid_pkg::wr_t       wr_o,
  output logic [30:0]        radius_o,
  output logic [31:0]        ra_o,
  output logic [31:0]        rb_o
);

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sq_t;

  function automatic sq_t sq_step(input sq_t s, input int n);
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_t         r;
    bitv  = 64'd1 << (62 - 2 * n);
    trial = s.res + bitv;
    if (s.rem >= trial) begin
      r.rem = s.rem - trial;
      r.res = (s.res >> 1) + bitv;
    end else begin
      r.rem = s.rem;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  sq_t           a_q   [tid_pkg::SQ_STEPS];
  sq_t           b_q   [tid_pkg::SQ_STEPS];
  tid_pkg::ctl_t ctl_q [tid_pkg::SQ_STEPS];
  tid_pkg::wr_t  wr_q  [tid_pkg::SQ_STEPS];
  logic [30:0]   rad_q [tid_pkg::SQ_STEPS];

  for (genvar i = 0; i < tid_pkg::SQ_STEPS; i++) begin : g_stage
    sq_t           a_in;
    sq_t           b_in;
    tid_pkg::ctl_t c_in;
    tid_pkg::wr_t  w_in;
    logic [30:0]   r_in;

    if (i == 0) begin : g_first
      assign a_in = '{rem: xa_i, res: 64'd0};
      assign b_in = '{rem: xb_i, res: 64'd0};
      assign c_in = ctl_i;
      assign w_in = wr_i;
      assign r_in = radius_i;
    end else begin : g_next
      assign a_in = a_q[i-1];
      assign b_in = b_q[i-1];
      assign c_in = ctl_q[i-1];
      assign w_in = wr_q[i-1];
      assign r_in = rad_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (adv_i) begin
        ctl_q[i] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_q[i]   <= sq_step(a_in, i);
        b_q[i]   <= sq_step(b_in, i);
        wr_q[i]  <= w_in;
        rad_q[i] <= r_in;
      end
    end
  end

  assign ctl_o    = ctl_q[tid_pkg::SQ_STEPS-1];
  assign wr_o     = wr_q[tid_pkg::SQ_STEPS-1];
  assign radius_o = rad_q[tid_pkg::SQ_STEPS-1];
  assign ra_o     = a_q[tid_pkg::SQ_STEPS-1].res[31:0];
  assign rb_o     = b_q[tid_pkg::SQ_STEPS-1].res[31:0];

endmodule

`default_nettype wire

// File: design/tid_lookup.sv
// Index scaling, range check and table lookup for two radii; also takes table writes.
// Depends on tid_pkg and tid_ram.
`default_nettype none

module tid_lookup (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire tid_pkg::ctl_t ctl_i,
  input  wire tid_pkg::wr_t  wr_i,
  input  wire logic [31:0]   ra_i,
  input  wire logic [31:0]   rb_i,
  input  wire logic [30:0]   step_inverse_i,
  output tid_pkg::ctl_t      ctl_o,
  output logic [15:0]        pa_o,
  output logic [15:0]        pb_o,
  output tid_pkg::trip_t     va_o,
  output tid_pkg::trip_t     vb_o
);

  tid_pkg::ctl_t ctl1_q;
  tid_pkg::ctl_t ctl2_q;
  tid_pkg::ctl_t ctl2_d;
  tid_pkg::wr_t  wr1_q;
  logic [62:0]   prod_a_q;
  logic [62:0]   prod_b_q;
  logic [15:0]   pa_q;
  logic [15:0]   pb_q;
  logic [30:0]   l_a;
  logic [30:0]   l_b;
  logic          we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_a_q <= 63'(ra_i) * 63'(step_inverse_i);
      prod_b_q <= 63'(rb_i) * 63'(step_inverse_i);
      wr1_q    <= wr_i;
      pa_q     <= prod_a_q[31:16];
      pb_q     <= prod_b_q[31:16];
    end
  end

  // Integer part of the scaled radius picks the first of three samples.
  assign l_a = prod_a_q[62:32];
  assign l_b = prod_b_q[62:32];

  always_comb begin
    ctl2_d       = ctl1_q;
    ctl2_d.oob_a = (32'(l_a) + 32'd2) >= 32'(tid_pkg::TABLE_DEPTH);
    ctl2_d.oob_b = (32'(l_b) + 32'd2) >= 32'(tid_pkg::TABLE_DEPTH);
  end

  assign we = adv_i && ctl1_q.valid && (ctl1_q.cmd == tid_pkg::CMD_WRITE) &&
              (32'(wr1_q.idx) < 32'(tid_pkg::TABLE_DEPTH));

  // Three copies of the table: copy k serves sample l+k for both radii.
  for (genvar k = 0; k < 3; k++) begin : g_copy
    tid_ram #(
      .WIDTH (32),
      .DEPTH (tid_pkg::TABLE_DEPTH)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (we),
      .waddr_i   (tid_pkg::ADDR_W'(wr1_q.idx)),
      .wdata_i   (wr1_q.data),
      .re_i      (adv_i),
      .raddr_a_i (l_a[tid_pkg::ADDR_W-1:0] + tid_pkg::ADDR_W'(k)),
      .raddr_b_i (l_b[tid_pkg::ADDR_W-1:0] + tid_pkg::ADDR_W'(k)),
      .rdata_a_o (va_o[k]),
      .rdata_b_o (vb_o[k])
    );
  end

  assign ctl_o = ctl2_q;
  assign pa_o  = pa_q;
  assign pb_o  = pb_q;

endmodule

`default_nettype wire

// File: design/tid_interp.sv
// Four-stage three-point quadratic interpolation for two lanes.
// Depends on tid_pkg.
`default_nettype none

module tid_interp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire tid_pkg::ctl_t ctl_i,
  input  wire logic [15:0]   pa_i,
  input  wire logic [15:0]   pb_i,
  input  wire tid_pkg::trip_t va_i,
  input  wire tid_pkg::trip_t vb_i,
  output tid_pkg::ctl_t      ctl_o,
  output logic [31:0]        fa_o,
  output logic [31:0]        fb_o
);

  tid_pkg::ctl_t ctl_q [4];

  tid_pkg::trip_t v [2];
  logic [15:0]    p [2];

  logic signed [50:0] m1_q [2];
  logic signed [50:0] m2_q [2];
  logic signed [31:0] v0_q [2];
  logic signed [31:0] v1_q [2];
  logic [15:0]        pd_q [2];
  logic signed [39:0] t1_q [2];
  logic signed [39:0] t2_q [2];
  logic [15:0]        pe_q [2];
  logic signed [57:0] m3_q [2];
  logic signed [39:0] t1f_q [2];
  logic [31:0]        f_q  [2];

  logic signed [32:0] d10 [2];
  logic signed [32:0] d21 [2];
  logic signed [17:0] pm1 [2];
  logic signed [40:0] d21t [2];

  assign v[0] = va_i;
  assign v[1] = vb_i;
  assign p[0] = pa_i;
  assign p[1] = pb_i;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      d10[k]  = $signed({v[k][1][31], v[k][1]}) - $signed({v[k][0][31], v[k][0]});
      d21[k]  = $signed({v[k][2][31], v[k][2]}) - $signed({v[k][1][31], v[k][1]});
      pm1[k]  = $signed({2'b00, p[k]}) - 18'sd65536;
      d21t[k] = 41'(t2_q[k]) - 41'(t1_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 4; s++) ctl_q[s] <= '0;
    end else if (adv_i) begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < 4; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 2; k++) begin
        m1_q[k]  <= 51'(d10[k]) * 51'($signed({1'b0, p[k]}));
        m2_q[k]  <= 51'(d21[k]) * 51'(pm1[k]);
        v0_q[k]  <= $signed(v[k][0]);
        v1_q[k]  <= $signed(v[k][1]);
        pd_q[k]  <= p[k];
        t1_q[k]  <= 40'(v0_q[k]) + 40'(m1_q[k] >>> 16);
        t2_q[k]  <= 40'(v1_q[k]) + 40'(m2_q[k] >>> 16);
        pe_q[k]  <= pd_q[k];
        m3_q[k]  <= 58'(d21t[k]) * 58'($signed({1'b0, pe_q[k]}));
        t1f_q[k] <= t1_q[k];
        f_q[k]   <= tid_pkg::sat_value(64'(t1f_q[k]) + 64'(m3_q[k] >>> 17));
      end
    end
  end

  assign ctl_o = ctl_q[3];
  assign fa_o  = f_q[0];
  assign fb_o  = f_q[1];

endmodule

`default_nettype wire

// File: design/tabulated_interp_fd_derivative.sv
// Top level: tabulated radial function with interpolation and finite-difference derivative.
// Depends on tid_pkg, tid_sqrt, tid_lookup, tid_interp and tid_ram.
//
//   Channel   Direction  Handshake              Contents
//   s_axis    in         tvalid/tready          command word (tuser) and operands (tdata)
//   m_axis    out        tvalid/tready          result value (tdata) and status (tuser)
//   cfg       in         cfg_valid_i/ready_o    register index and write data
//
// A word may enter every clock; one result word leaves for every input word, in order.
// A word passes two front stages, the 32-stage square root pipeline (one root bit
// per stage), two lookup stages, four interpolation stages, the derivative multiply and
// the output register. The table memories are undefined after reset and need no clearing.
// A stall on m_axis freezes the pipeline, except that an empty slot ahead of the output
// register is squeezed out, so input is still taken while a result waits.
`default_nettype none

module tabulated_interp_fd_derivative (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: entry_index[11:0], entry_value[31:0], squared_term[30:0],
  // offset[31:0], radius[30:0], six zero pad bits
  input  wire logic [143:0] s_axis_tdata,
  // tuser from bit 0: command[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: value[31:0]
  output logic [31:0]       m_axis_tdata,
  // tuser from bit 0: status[1:0]
  output logic [1:0]        m_axis_tuser,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  // Configuration registers; the user must write them only while the pipeline is idle (not enforced here).
  logic [30:0] step_inverse_q;
  logic [30:0] two_h_q;
  logic [30:0] inv_two_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_inverse_q <= 31'd65536;
      two_h_q        <= '0;
      inv_two_h_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tid_pkg::CFG_STEP_INV:  step_inverse_q <= cfg_data_i[30:0];
        tid_pkg::CFG_TWO_H:     two_h_q        <= cfg_data_i[30:0];
        tid_pkg::CFG_INV_TWO_H: inv_two_h_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic [11:0] in_idx;
  logic [31:0] in_val;
  logic [30:0] in_s;
  logic [31:0] in_t;
  logic [30:0] in_r;

  assign in_idx = s_axis_tdata[11:0];
  assign in_val = s_axis_tdata[43:12];
  assign in_s   = s_axis_tdata[74:44];
  assign in_t   = s_axis_tdata[106:75];
  assign in_r   = s_axis_tdata[137:107];

  // The whole pipeline moves together. It moves when the output can take a word or
  // when the stage in front of the output is empty.
  logic adv;
  logic out_load;
  tid_pkg::ctl_t h_ctl_q;
  logic out_valid_q;

  assign adv           = m_axis_tready || !out_valid_q || !h_ctl_q.valid;
  assign out_load      = m_axis_tready || !out_valid_q;
  assign s_axis_tready = adv;

  // Front stage 1: offset times two_h.
  tid_pkg::ctl_t      ctl1_q;
  tid_pkg::ctl_t      ctl1_d;
  tid_pkg::wr_t       wr1_q;
  logic [30:0]        s1_q;
  logic [30:0]        r1_q;
  logic signed [63:0] tth_prod_q;

  always_comb begin
    ctl1_d       = '0;
    ctl1_d.valid = s_axis_tvalid;
    ctl1_d.cmd   = tid_pkg::cmd_e'(s_axis_tuser);
  end

  // Front stage 2: the two root arguments and their sign check.
  tid_pkg::ctl_t      ctl2_q;
  tid_pkg::ctl_t      ctl2_d;
  tid_pkg::wr_t       wr2_q;
  logic [30:0]        r2_q;
  logic [63:0]        xa_q;
  logic [63:0]        xb_q;
  logic signed [47:0] tth;
  logic signed [48:0] am;
  logic signed [48:0] ap;

  assign tth = 48'(tth_prod_q >>> 16);
  assign am  = $signed({18'b0, s1_q}) - 49'(tth);
  assign ap  = $signed({18'b0, s1_q}) + 49'(tth);

  always_comb begin
    ctl2_d     = ctl1_q;
    ctl2_d.neg = am[48] || ap[48];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr1_q      <= '{idx: in_idx, data: in_val};
      s1_q       <= in_s;
      r1_q       <= in_r;
      tth_prod_q <= 64'($signed(in_t)) * 64'($signed({1'b0, two_h_q}));
      wr2_q      <= wr1_q;
      r2_q       <= r1_q;
      xa_q       <= {am[47:0], 16'b0};
      xb_q       <= {ap[47:0], 16'b0};
    end
  end

  // Square roots of both arguments.
  tid_pkg::ctl_t sq_ctl;
  tid_pkg::wr_t  sq_wr;
  logic [30:0]   sq_rad;
  logic [31:0]   sq_ra;
  logic [31:0]   sq_rb;
  logic [31:0]   lk_ra;

  tid_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .ctl_i    (ctl2_q),
    .wr_i     (wr2_q),
    .radius_i (r2_q),
    .xa_i     (xa_q),
    .xb_i     (xb_q),
    .ctl_o    (sq_ctl),
    .wr_o     (sq_wr),
    .radius_o (sq_rad),
    .ra_o     (sq_ra),
    .rb_o     (sq_rb)
  );

  // Direct interpolation uses the given radius in lane a.
  assign lk_ra = (sq_ctl.cmd == tid_pkg::CMD_INTERP) ? {1'b0, sq_rad} : sq_ra;

  tid_pkg::ctl_t  lk_ctl;
  logic [15:0]    lk_pa;
  logic [15:0]    lk_pb;
  tid_pkg::trip_t lk_va;
  tid_pkg::trip_t lk_vb;

  tid_lookup u_lookup (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .ctl_i          (sq_ctl),
    .wr_i           (sq_wr),
    .ra_i           (lk_ra),
    .rb_i           (sq_rb),
    .step_inverse_i (step_inverse_q),
    .ctl_o          (lk_ctl),
    .pa_o           (lk_pa),
    .pb_o           (lk_pb),
    .va_o           (lk_va),
    .vb_o           (lk_vb)
  );

  tid_pkg::ctl_t ip_ctl;
  logic [31:0]   ip_fa;
  logic [31:0]   ip_fb;

  tid_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (lk_ctl),
    .pa_i   (lk_pa),
    .pb_i   (lk_pb),
    .va_i   (lk_va),
    .vb_i   (lk_vb),
    .ctl_o  (ip_ctl),
    .fa_o   (ip_fa),
    .fb_o   (ip_fb)
  );

  // Derivative stage: difference of the two samples times inv_two_h.
  logic signed [65:0] h_prod_q;
  logic [31:0]        h_fa_q;
  logic signed [32:0] diff;

  assign diff = $signed({ip_fa[31], ip_fa}) - $signed({ip_fb[31], ip_fb});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_ctl_q <= '0;
    end else if (adv) begin
      h_ctl_q <= ip_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_prod_q <= 66'(diff) * 66'($signed({1'b0, inv_two_h_q}));
      h_fa_q   <= ip_fa;
    end
  end

  // Result selection and output register.
  logic [31:0]       res_value;
  tid_pkg::status_e  res_status;
  logic [31:0]       out_value_q;
  tid_pkg::status_e  out_status_q;

  always_comb begin
    res_value  = '0;
    res_status = tid_pkg::ST_OK;
    unique case (h_ctl_q.cmd)
      tid_pkg::CMD_DERIV: begin
        if (h_ctl_q.neg) begin
          res_status = tid_pkg::ST_NEG;
        end else if (h_ctl_q.oob_a || h_ctl_q.oob_b) begin
          res_status = tid_pkg::ST_RANGE;
        end else begin
          res_value = tid_pkg::sat_value(64'(h_prod_q >>> 16));
        end
      end
      tid_pkg::CMD_INTERP: begin
        if (h_ctl_q.oob_a) begin
          res_status = tid_pkg::ST_RANGE;
        end else begin
          res_value = h_fa_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= h_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  // A flagged result always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != tid_pkg::ST_OK)) |-> (out_value_q == 32'd0))
    else $error("flagged result with nonzero value");

  // Input is refused only while a result waits and the stage behind it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && !m_axis_tready && h_ctl_q.valid))
    else $error("input refused without cause");

  // A new output word comes only from a full derivative stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(h_ctl_q.valid))
    else $error("output word appeared from an empty stage");

endmodule

`default_nettype wire
